@@ rtl/smpd_pkg.sv @@
// ----------------------------------------------------------------------------
// smpd_pkg
// Shared constants and controller/datapath types for the serial mouse
// packet decoder.
// ----------------------------------------------------------------------------
package smpd_pkg;

   // Header byte recognition: top five bits 10000
   localparam logic [7:0] HEADER_MASK = 8'hF8;
   localparam logic [7:0] HEADER_MARK = 8'h80;

   // Deltas with magnitude above this get accelerated in the second update
   localparam int ACCEL_LIMIT = 3;

   // Signed width of an (accelerated) delta: |d + 3d/1| <= 512
   localparam int DELTA_W = 11;

   // Divider sizing: dividend 3*|d| <= 384, 8-bit divisor
   localparam int QUO_W     = 9;
   localparam int DIVISOR_W = 8;
   localparam int CNT_W     = 4;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_X         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Y         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_X         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_Y         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_DIVISOR = 3'd4;

   // Configuration reset values
   localparam int MIN_X_RESET         = 0;
   localparam int MIN_Y_RESET         = 0;
   localparam int MAX_X_RESET         = 639;
   localparam int MAX_Y_RESET         = 479;
   localparam int ACCEL_DIVISOR_RESET = 6;

   // Which delta the divider works on
   localparam logic SEL_Y = 1'b0;
   localparam logic SEL_X = 1'b1;

   typedef struct packed {
      logic load_item;     // capture the accepted item
      logic set_pos;       // load cursor from the item
      logic store_header;  // keep header byte, count -> 1
      logic store_delta;   // keep first delta, count + 1
      logic load_plain;    // acc regs <= raw deltas
      logic div_start;     // start divider on 3*|d|
      logic div_start_sel;
      logic div_take;      // fold quotient into acc reg
      logic div_take_sel;
      logic update;        // apply acc regs to cursor, flip packet half
      logic load_out;      // move result into the output register
   } ctl_cmd_type;

   typedef struct packed {
      logic       command;
      logic       second_half;
      logic [1:0] byte_count;
      logic       header_ok;
      logic       div_done;
      logic       out_free;
   } dp_status_type;

endpackage

@@ rtl/smpd_req_if.sv @@
// ----------------------------------------------------------------------------
// smpd_req_if
// Request channel: received serial byte or set-position command.
// ----------------------------------------------------------------------------
interface smpd_req_if #(
   parameter int COORD_WIDTH = 12
);
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [7:0]             rx_byte;
   logic [COORD_WIDTH-1:0] new_x;
   logic [COORD_WIDTH-1:0] new_y;

   modport source (output valid, command, rx_byte, new_x, new_y, input ready);
   modport sink   (input valid, command, rx_byte, new_x, new_y, output ready);
endinterface

@@ rtl/smpd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// smpd_rsp_if
// Response channel: cursor position and button state after an update.
// ----------------------------------------------------------------------------
interface smpd_rsp_if #(
   parameter int COORD_WIDTH = 12
);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] pos_x;
   logic [COORD_WIDTH-1:0] pos_y;
   logic                   left_pressed;
   logic                   right_pressed;
   logic                   moved;

   modport source (output valid, pos_x, pos_y, left_pressed, right_pressed, moved,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, left_pressed, right_pressed, moved,
                   output ready);
endinterface

@@ rtl/smpd_divider.sv @@
// ----------------------------------------------------------------------------
// smpd_divider
// Restoring radix-2 divider, one quotient bit per cycle. A zero divisor
// is treated as one.
// ----------------------------------------------------------------------------
module smpd_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [smpd_pkg::QUO_W-1:0]     dividend,
   input  logic [smpd_pkg::DIVISOR_W-1:0] divisor,
   output logic                           done,
   output logic [smpd_pkg::QUO_W-1:0]     quotient
);
   import smpd_pkg::*;

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[QUO_W-1]};
      diff    = shifted - {1'b0, div_ff};
      fits    = (shifted >= {1'b0, div_ff});

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = (divisor == '0) ? DIVISOR_W'(1) : divisor;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/smpd_datapath.sv @@
// ----------------------------------------------------------------------------
// smpd_datapath
// Packet state, cursor arithmetic, clamping, acceleration, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module smpd_datapath #(
   parameter int COORD_WIDTH = 12,
   parameter int CSR_W       = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  smpd_pkg::ctl_cmd_type           cmd,
   output smpd_pkg::dp_status_type         status,
   // request payload
   input  logic                            req_command,
   input  logic [7:0]                      req_rx_byte,
   input  logic [COORD_WIDTH-1:0]          req_new_x,
   input  logic [COORD_WIDTH-1:0]          req_new_y,
   // configuration
   input  logic                            csr_we,
   input  logic [smpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]                csr_wdata,
   // response
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [COORD_WIDTH-1:0]          rsp_pos_x,
   output logic [COORD_WIDTH-1:0]          rsp_pos_y,
   output logic                            rsp_left_pressed,
   output logic                            rsp_right_pressed,
   output logic                            rsp_moved
);
   import smpd_pkg::*;

   localparam int SUM_W = ((COORD_WIDTH + 2) > (DELTA_W + 1)) ? (COORD_WIDTH + 2)
                                                                : (DELTA_W + 1);

   // configuration
   logic [COORD_WIDTH-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic [DIVISOR_W-1:0]   accel_div_ff;

   // captured item
   logic                   item_cmd_ff;
   logic [7:0]             item_byte_ff;
   logic [COORD_WIDTH-1:0] item_x_ff, item_y_ff;

   // packet state
   logic                   second_half_ff;
   logic [1:0]             byte_count_ff;
   logic [7:0]             header_ff;
   logic [7:0]             first_delta_ff;
   logic [COORD_WIDTH-1:0] cur_x_ff, cur_y_ff;
   logic                   left_ff, right_ff;
   logic                   moved_ff;

   // working deltas
   logic signed [DELTA_W-1:0] acc_x_ff, acc_y_ff;

   // output register
   logic                   out_valid_ff;
   logic [COORD_WIDTH-1:0] out_x_ff, out_y_ff;
   logic                   out_left_ff, out_right_ff, out_moved_ff;

   // divider
   logic [QUO_W-1:0]       div_dividend, div_quotient;
   logic                   div_done;

   logic [7:0]             mag_x, mag_y, start_mag, take_mag;
   logic                   take_neg, take_big;
   logic signed [DELTA_W-1:0] q_ext, q_signed, take_acc;

   logic signed [SUM_W-1:0] sum_x, sum_y, lo_x, hi_x, lo_y, hi_y, clamp_x, clamp_y;
   logic [COORD_WIDTH-1:0] new_x, new_y;

   // magnitudes of the two raw deltas (-128 maps to 128)
   assign mag_x = item_byte_ff[7] ? 8'(-item_byte_ff) : item_byte_ff;
   assign mag_y = first_delta_ff[7] ? 8'(-first_delta_ff) : first_delta_ff;

   assign start_mag    = (cmd.div_start_sel == SEL_X) ? mag_x : mag_y;
   assign div_dividend = {1'b0, start_mag} + {start_mag, 1'b0};

   smpd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (accel_div_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      take_mag = (cmd.div_take_sel == SEL_X) ? mag_x : mag_y;
      take_neg = (cmd.div_take_sel == SEL_X) ? item_byte_ff[7] : first_delta_ff[7];
      take_big = (take_mag > 8'(ACCEL_LIMIT));
      take_acc = (cmd.div_take_sel == SEL_X) ? acc_x_ff : acc_y_ff;
      q_ext    = signed'({{(DELTA_W-QUO_W){1'b0}}, div_quotient});
      // quotient truncates toward zero: apply with the sign of d
      q_signed = take_neg ? -q_ext : q_ext;
   end

   // x drops by its delta, y rises by its delta; clamp to max then min
   always_comb begin
      sum_x = signed'({{(SUM_W-COORD_WIDTH){1'b0}}, cur_x_ff})
            - {{(SUM_W-DELTA_W){acc_x_ff[DELTA_W-1]}}, acc_x_ff};
      sum_y = signed'({{(SUM_W-COORD_WIDTH){1'b0}}, cur_y_ff})
            + {{(SUM_W-DELTA_W){acc_y_ff[DELTA_W-1]}}, acc_y_ff};
      lo_x  = signed'({{(SUM_W-COORD_WIDTH){1'b0}}, min_x_ff});
      hi_x  = signed'({{(SUM_W-COORD_WIDTH){1'b0}}, max_x_ff});
      lo_y  = signed'({{(SUM_W-COORD_WIDTH){1'b0}}, min_y_ff});
      hi_y  = signed'({{(SUM_W-COORD_WIDTH){1'b0}}, max_y_ff});

      clamp_x = (sum_x > hi_x) ? hi_x : sum_x;
      if (clamp_x < lo_x) clamp_x = lo_x;
      clamp_y = (sum_y > hi_y) ? hi_y : sum_y;
      if (clamp_y < lo_y) clamp_y = lo_y;

      new_x = clamp_x[COORD_WIDTH-1:0];
      new_y = clamp_y[COORD_WIDTH-1:0];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff     <= COORD_WIDTH'(MIN_X_RESET);
         min_y_ff     <= COORD_WIDTH'(MIN_Y_RESET);
         max_x_ff     <= COORD_WIDTH'(MAX_X_RESET);
         max_y_ff     <= COORD_WIDTH'(MAX_Y_RESET);
         accel_div_ff <= DIVISOR_W'(ACCEL_DIVISOR_RESET);
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_X:         min_x_ff     <= csr_wdata[COORD_WIDTH-1:0];
            REG_MIN_Y:         min_y_ff     <= csr_wdata[COORD_WIDTH-1:0];
            REG_MAX_X:         max_x_ff     <= csr_wdata[COORD_WIDTH-1:0];
            REG_MAX_Y:         max_y_ff     <= csr_wdata[COORD_WIDTH-1:0];
            REG_ACCEL_DIVISOR: accel_div_ff <= csr_wdata[DIVISOR_W-1:0];
            default: ;
         endcase
      end
   end

   // packet state and cursor
   always_ff @(posedge clock) begin
      if (reset) begin
         second_half_ff <= 1'b0;
         byte_count_ff  <= '0;
         header_ff      <= '0;
         first_delta_ff <= '0;
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         left_ff        <= 1'b0;
         right_ff       <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (cmd.set_pos) begin
            cur_x_ff <= item_x_ff;
            cur_y_ff <= item_y_ff;
         end
         if (cmd.store_header) begin
            header_ff     <= item_byte_ff;
            byte_count_ff <= 2'd1;
         end
         if (cmd.store_delta) begin
            first_delta_ff <= item_byte_ff;
            byte_count_ff  <= byte_count_ff + 2'd1;
         end
         if (cmd.update) begin
            cur_x_ff       <= new_x;
            cur_y_ff       <= new_y;
            second_half_ff <= ~second_half_ff;
            byte_count_ff  <= '0;
            if (!second_half_ff) begin
               right_ff <= ~header_ff[0];
               left_ff  <= ~header_ff[2];
            end
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_cmd_ff  <= req_command;
         item_byte_ff <= req_rx_byte;
         item_x_ff    <= req_new_x;
         item_y_ff    <= req_new_y;
      end
      if (cmd.load_plain) begin
         acc_x_ff <= DELTA_W'(signed'(item_byte_ff));
         acc_y_ff <= DELTA_W'(signed'(first_delta_ff));
      end else if (cmd.div_take && take_big) begin
         if (cmd.div_take_sel == SEL_X) acc_x_ff <= take_acc + q_signed;
         else                           acc_y_ff <= take_acc + q_signed;
      end
      if (cmd.update) begin
         moved_ff <= (new_x != cur_x_ff) || (new_y != cur_y_ff);
      end
      if (cmd.load_out) begin
         out_x_ff     <= cur_x_ff;
         out_y_ff     <= cur_y_ff;
         out_left_ff  <= left_ff;
         out_right_ff <= right_ff;
         out_moved_ff <= moved_ff;
      end
   end

   assign status.command     = item_cmd_ff;
   assign status.second_half = second_half_ff;
   assign status.byte_count  = byte_count_ff;
   assign status.header_ok   = ((item_byte_ff & HEADER_MASK) == HEADER_MARK);
   assign status.div_done    = div_done;
   assign status.out_free    = !out_valid_ff || rsp_ready;

   assign rsp_valid         = out_valid_ff;
   assign rsp_pos_x         = out_x_ff;
   assign rsp_pos_y         = out_y_ff;
   assign rsp_left_pressed  = out_left_ff;
   assign rsp_right_pressed = out_right_ff;
   assign rsp_moved         = out_moved_ff;

endmodule

@@ rtl/smpd_controller.sv @@
// ----------------------------------------------------------------------------
// smpd_controller
// Sequencer: takes one item, decodes it against the packet phase and
// steps the datapath through divide, update and result hand-off.
// ----------------------------------------------------------------------------
module smpd_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  smpd_pkg::dp_status_type  status,
   output smpd_pkg::ctl_cmd_type    cmd
);
   import smpd_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_DIV_Y  = 3'd2;
   localparam logic [2:0] S_DIV_X  = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            if (status.command) begin
               cmd.set_pos = 1'b1;
            end else if (!status.second_half) begin
               case (status.byte_count)
                  2'd0: cmd.store_header = status.header_ok;
                  2'd1: cmd.store_delta  = 1'b1;
                  2'd2: begin
                     cmd.load_plain = 1'b1;
                     state_in       = S_UPDATE;
                  end
                  default: ;
               endcase
            end else if (status.byte_count == 2'd0) begin
               cmd.store_delta = 1'b1;
            end else begin
               // fifth byte: accelerate y then x through the shared divider
               cmd.load_plain    = 1'b1;
               cmd.div_start     = 1'b1;
               cmd.div_start_sel = SEL_Y;
               state_in          = S_DIV_Y;
            end
         end
         S_DIV_Y: begin
            if (status.div_done) begin
               cmd.div_take      = 1'b1;
               cmd.div_take_sel  = SEL_Y;
               cmd.div_start     = 1'b1;
               cmd.div_start_sel = SEL_X;
               state_in          = S_DIV_X;
            end
         end
         S_DIV_X: begin
            if (status.div_done) begin
               cmd.div_take     = 1'b1;
               cmd.div_take_sel = SEL_X;
               state_in         = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/serial_mouse_packet_decoder.sv @@
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder
// Five-byte serial mouse packet decoder with cursor tracking.
// ----------------------------------------------------------------------------
// req_chan carries either a received serial byte (command = 0) or a
// set-position command (command = 1, loads new_x/new_y, no response).
// rsp_chan gives one cursor/button result after the third and after the
// fifth byte of a packet. Bytes before a header are dropped silently.
// csr_* is a write-only port for min/max limits and the acceleration
// divisor; write it only while the block is idle.
// Sequence: a byte that gives no result goes through transfer and decode.
// The third byte goes on through update and emit to its result. The fifth
// byte runs both deltas, y then x, through one shared radix-2 divider
// before its update and emit.
// Reset returns the limits to 0/0/639/479, the divisor to 6, the cursor
// to 0,0 and the decoder to waiting for a header.
// A stalled rsp_chan does not block req_chan: the next item is taken
// while the result waits in the output register; only an item that has
// its own result waits for that register to drain.
// ----------------------------------------------------------------------------
module serial_mouse_packet_decoder #(
   parameter int  COORD_WIDTH = 12,
   localparam int CSR_W       = (COORD_WIDTH > 8) ? COORD_WIDTH : 8
) (
   input  logic                           clock,
   input  logic                           reset,
   smpd_req_if.sink                       req_chan,
   smpd_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [smpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]               csr_wdata
);
   import smpd_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   smpd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   smpd_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .CSR_W       (CSR_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_command       (req_chan.command),
      .req_rx_byte       (req_chan.rx_byte),
      .req_new_x         (req_chan.new_x),
      .req_new_y         (req_chan.new_y),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_pos_x         (rsp_chan.pos_x),
      .rsp_pos_y         (rsp_chan.pos_y),
      .rsp_left_pressed  (rsp_chan.left_pressed),
      .rsp_right_pressed (rsp_chan.right_pressed),
      .rsp_moved         (rsp_chan.moved)
   );

endmodule
